### design/rscx_pkg.sv
`default_nettype none

package rscx_pkg;

  // widths fixed by the item format
  localparam int unsigned ValW     = 32;
  localparam int unsigned RandW    = 31;
  localparam int unsigned ProbW    = 16;
  localparam int unsigned LenW     = 7;
  localparam int unsigned GeneW    = 6;
  localparam int unsigned ParentW  = 8;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned EntW     = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ModCntW  = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCrossProb = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGenomeLen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWheelEnt  = 2'd2;

  localparam logic [ProbW-1:0] CrossProbRst = 16'd52429;
  localparam logic [LenW-1:0]  GenomeLenRst = 7'd64;
  localparam logic [EntW-1:0]  WheelEntRst  = 9'd256;
  localparam logic [LenW-1:0]  MinLen       = 7'd3;

  // request kinds
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqChild = 1'b1;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic               done;
    logic [ParentW-1:0] parent;
  } srch_rsp_t;

endpackage

`default_nettype wire

### design/rscx_mod.sv
`default_nettype none

module rscx_mod
  import rscx_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RandW-1:0] dividend_i,
  input  wire logic [ValW-1:0]  divisor_i,
  output mod_rsp_t              rsp_o
);

  localparam logic [ModCntW-1:0] LastCnt = ModCntW'(RandW - 1);

  logic               busy_q, done_q;
  logic [ModCntW-1:0] cnt_q;
  logic [RandW-1:0]   dvd_q;
  logic [ValW-1:0]    dvs_q, rem_q;
  logic [ValW-1:0]    shifted, rem_d;

  // one quotient bit per cycle, remainder stays below 2^31
  always_comb begin
    shifted = {rem_q[ValW-2:0], dvd_q[RandW-1]};
    rem_d   = (shifted >= dvs_q) ? shifted - dvs_q : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RandW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

### design/rscx_wheel.sv
`default_nettype none

module rscx_wheel
  import rscx_pkg::*;
#(
  parameter int unsigned WHEEL_DEPTH = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire logic [ValW-1:0] wr_data_i,
  input  wire logic [EntW-1:0] entries_i,
  input  wire logic            srch_start_i,
  input  wire logic [ValW-1:0] srch_target_i,
  output logic      [ValW-1:0] wheel_max_o,
  output srch_rsp_t            srch_rsp_o
);

  localparam int unsigned AddrW = (WHEEL_DEPTH > 1) ? $clog2(WHEEL_DEPTH) : 1;
  localparam int unsigned PosW  = $clog2(WHEEL_DEPTH + 1);

  logic [ValW-1:0]  mem_q [WHEEL_DEPTH];
  logic [ValW-1:0]  rdata_q;
  logic [ValW-1:0]  max_q;
  logic [ValW-1:0]  target_q;
  logic             active_q, pend_q;
  logic [PosW-1:0]  addr_q, pend_pos_q;
  srch_rsp_t        rsp_q;

  logic             wr_ok, re, hit, miss_end;
  logic [AddrW-1:0] waddr, raddr;
  logic [PosW-1:0]  n_ent, fin_pos, fin_par;

  always_comb begin
    wr_ok = wr_en_i && (32'(wr_idx_i) < 32'(WHEEL_DEPTH));
    waddr = AddrW'(wr_idx_i);
    if (32'(entries_i) > 32'(WHEEL_DEPTH)) begin
      n_ent = PosW'(WHEEL_DEPTH);
    end else begin
      n_ent = PosW'(entries_i);
    end
    hit      = active_q && pend_q && (rdata_q >= target_q);
    miss_end = active_q && !pend_q && (addr_q == n_ent);
    re       = active_q && !hit && !miss_end && (addr_q < n_ent);
    raddr    = addr_q[AddrW-1:0];
    fin_pos  = hit ? pend_pos_q : addr_q;
    fin_par  = (fin_pos == '0) ? '0 : fin_pos - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[waddr] <= wr_data_i;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // reads run one ahead of the compare, and a hit gates off the read of the next entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= '0;
      active_q   <= 1'b0;
      pend_q     <= 1'b0;
      addr_q     <= '0;
      pend_pos_q <= '0;
      target_q   <= '0;
      rsp_q      <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      if (wr_ok && ((wr_idx_i == '0) || (wr_data_i > max_q))) begin
        max_q <= wr_data_i;
      end
      if (srch_start_i) begin
        active_q <= 1'b1;
        pend_q   <= 1'b0;
        addr_q   <= '0;
        target_q <= srch_target_i;
      end else if (hit || miss_end) begin
        active_q          <= 1'b0;
        pend_q            <= 1'b0;
        rsp_q.done        <= 1'b1;
        rsp_q.parent      <= ParentW'(fin_par);
      end else if (active_q) begin
        pend_q     <= re;
        pend_pos_q <= addr_q;
        if (re) begin
          addr_q <= addr_q + 1'b1;
        end
      end
    end
  end

  assign wheel_max_o = max_q;
  assign srch_rsp_o  = rsp_q;

endmodule

`default_nettype wire

### design/roulette_select_one_point_crossover.sv
// Roulette-wheel parent selector with one-point crossover or cloning.
// Request channel: an item is taken at a clock edge with start_i high and
// busy_o low. A load item (req_type_i = 0) writes entry_value_i to wheel
// entry entry_index_i and updates the wheel maximum at that edge; busy_o
// stays low, so loads may follow back to back. A child request
// (req_type_i = 1) raises busy_o until its last gene has been issued.
// Child flow: each remainder (two parent draws, plus the crossover point
// when crossing) runs 31 steps on one shared serial divider; each linear
// wheel search reads one entry per cycle from the synchronous wheel memory
// over at most wheel_entries entries, limited to WHEEL_DEPTH; then the
// block issues one result per cycle for every gene. A new request can
// follow once busy_o is low again.
// Results appear on the result ports for one cycle each with out_valid_o;
// the receiver must take them, there is no back-pressure.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; written only while idle by the user, unchecked by the block.
// Reset clears the control state and wheel maximum and loads the register
// defaults; the wheel memory holds no data until it is loaded.
`default_nettype none

module roulette_select_one_point_crossover
  import rscx_pkg::*;
#(
  parameter int unsigned WHEEL_DEPTH = 256,
  parameter int unsigned MAX_GENES   = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic                req_type_i,
  input  wire logic [IdxW-1:0]     entry_index_i,
  input  wire logic [ValW-1:0]     entry_value_i,
  input  wire logic [RandW-1:0]    rand_pick_a_i,
  input  wire logic [RandW-1:0]    rand_pick_b_i,
  input  wire logic [RandW-1:0]    rand_point_i,
  input  wire logic [ProbW-1:0]    rand_prob_i,
  input  wire logic                rand_clone_pick_i,
  output logic                     out_valid_o,
  output logic [GeneW-1:0]         gene_index_o,
  output logic [ParentW-1:0]       source_parent_o,
  output logic                     did_crossover_o,
  output logic                     last_gene_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_GENES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODA,
    ST_SRCHA,
    ST_MODB,
    ST_SRCHB,
    ST_MODP,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [ProbW-1:0]   cross_prob_q;
  logic [LenW-1:0]    genome_len_q;
  logic [EntW-1:0]    wheel_ent_q;

  logic [RandW-1:0]   rand_b_q, rand_point_q;
  logic               cross_q, clone_q;
  logic [LenW-1:0]    len_q;
  logic [ParentW-1:0] pa_q, pb_q;
  logic [GeneW-1:0]   point_q, gene_q;

  logic               mod_start_q;
  logic [RandW-1:0]   mod_dvd_q;
  logic [ValW-1:0]    mod_dvs_q;
  logic               srch_start_q;
  logic [ValW-1:0]    srch_target_q;

  logic               out_valid_q, out_cross_q, out_last_q;
  logic [GeneW-1:0]   out_gene_q;
  logic [ParentW-1:0] out_src_q;

  mod_rsp_t           mod_rsp;
  srch_rsp_t          srch_rsp;
  logic [ValW-1:0]    wheel_max;

  logic               accept, load_req, is_last;
  logic [LenW-1:0]    len_clamped;
  logic [ValW-1:0]    pick_target;
  logic [ParentW-1:0] gene_src;

  always_comb begin
    accept   = start_i && (state_q == ST_IDLE);
    load_req = accept && (req_type_i == ReqLoad);
    if (genome_len_q < MinLen) begin
      len_clamped = MinLen;
    end else if (genome_len_q > MaxLen) begin
      len_clamped = MaxLen;
    end else begin
      len_clamped = genome_len_q;
    end
    // empty wheel draws the value one
    pick_target = (wheel_max == '0) ? ValW'(1) : mod_rsp.rem + 1'b1;
    is_last     = (LenW'(gene_q) == len_q - 1'b1);
    if (cross_q) begin
      gene_src = (gene_q < point_q) ? pa_q : pb_q;
    end else begin
      gene_src = clone_q ? pb_q : pa_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_prob_q <= CrossProbRst;
      genome_len_q <= GenomeLenRst;
      wheel_ent_q  <= WheelEntRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCrossProb: cross_prob_q <= cfg_data_i[ProbW-1:0];
        CfgGenomeLen: genome_len_q <= cfg_data_i[LenW-1:0];
        CfgWheelEnt:  wheel_ent_q  <= cfg_data_i[EntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mod_start_q  <= 1'b0;
      srch_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      mod_start_q  <= 1'b0;
      srch_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && (req_type_i == ReqChild)) begin
            rand_b_q     <= rand_pick_b_i;
            rand_point_q <= rand_point_i;
            cross_q      <= rand_prob_i < cross_prob_q;
            clone_q      <= rand_clone_pick_i;
            len_q        <= len_clamped;
            mod_dvd_q    <= rand_pick_a_i;
            mod_dvs_q    <= wheel_max;
            mod_start_q  <= 1'b1;
            state_q      <= ST_MODA;
          end
        end
        ST_MODA: begin
          if (mod_rsp.done) begin
            srch_target_q <= pick_target;
            srch_start_q  <= 1'b1;
            state_q       <= ST_SRCHA;
          end
        end
        ST_SRCHA: begin
          if (srch_rsp.done) begin
            pa_q        <= srch_rsp.parent;
            mod_dvd_q   <= rand_b_q;
            mod_dvs_q   <= wheel_max;
            mod_start_q <= 1'b1;
            state_q     <= ST_MODB;
          end
        end
        ST_MODB: begin
          if (mod_rsp.done) begin
            srch_target_q <= pick_target;
            srch_start_q  <= 1'b1;
            state_q       <= ST_SRCHB;
          end
        end
        ST_SRCHB: begin
          if (srch_rsp.done) begin
            pb_q   <= srch_rsp.parent;
            gene_q <= '0;
            if (cross_q) begin
              mod_dvd_q   <= rand_point_q;
              mod_dvs_q   <= ValW'(len_q - 7'd2);
              mod_start_q <= 1'b1;
              state_q     <= ST_MODP;
            end else begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_MODP: begin
          if (mod_rsp.done) begin
            point_q <= GeneW'(mod_rsp.rem) + 1'b1;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          out_valid_q <= 1'b1;
          out_gene_q  <= gene_q;
          out_src_q   <= gene_src;
          out_cross_q <= cross_q;
          out_last_q  <= is_last;
          gene_q      <= gene_q + 1'b1;
          if (is_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  rscx_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start_q),
    .dividend_i (mod_dvd_q),
    .divisor_i  (mod_dvs_q),
    .rsp_o      (mod_rsp)
  );

  rscx_wheel #(
    .WHEEL_DEPTH (WHEEL_DEPTH)
  ) u_wheel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (load_req),
    .wr_idx_i      (entry_index_i),
    .wr_data_i     (entry_value_i),
    .entries_i     (wheel_ent_q),
    .srch_start_i  (srch_start_q),
    .srch_target_i (srch_target_q),
    .wheel_max_o   (wheel_max),
    .srch_rsp_o    (srch_rsp)
  );

  assign busy_o          = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign gene_index_o    = out_gene_q;
  assign source_parent_o = out_src_q;
  assign did_crossover_o = out_cross_q;
  assign last_gene_o     = out_last_q;

endmodule

`default_nettype wire

### design/rscx_chk.sv
`default_nettype none

module rscx_chk
  import rscx_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               req_type_i,
  input wire logic               out_valid_o,
  input wire logic [GeneW-1:0]   gene_index_o,
  input wire logic               last_gene_o
);

  // a child request keeps the block busy
  a_child_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_type_i == ReqChild) |=> busy_o)
    else $error("child request did not raise busy");

  // every result is issued from work started while busy
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy_o))
    else $error("result outside a child request");

  // genes of one child come in a gapless run from zero
  a_first_gene: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (gene_index_o == '0))
    else $error("child does not start at gene zero");

  a_gene_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_gene_o |=>
      out_valid_o && (gene_index_o == $past(gene_index_o) + 1'b1))
    else $error("gene run broken");

  a_last_gene: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_gene_o |=> !out_valid_o)
    else $error("result after last gene");

endmodule

bind roulette_select_one_point_crossover rscx_chk u_chk (.*);

`default_nettype wire
